// ===== sv/gn3_pkg.sv =====
package gn3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_BITS_DEF  = 16;
  localparam int COORD_W       = 24;
  localparam int CELL_W        = 8;
  localparam int HASH_W        = 8;
  localparam int QUEUE_DEPTH   = 4;

  typedef logic [HASH_W-1:0] hash_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
    8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
    8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
    8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
    8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
    8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
    8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,
    8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,
    8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,
    8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,
    8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,
    8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
    8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  localparam logic [3:0] GRAD_12 = 4'd12;
  localparam logic [3:0] GRAD_14 = 4'd14;

  function automatic hash_t perm(input logic [7:0] idx);
    perm = PERM_ROM[idx];
  endfunction

endpackage

// ===== sv/gn3_front.sv =====
module gn3_front import gn3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic                      adv,
  output logic                      out_valid,
  output hash_t                     hash [8],
  output logic [FRAC_BITS-1:0]      fx,
  output logic [FRAC_BITS-1:0]      fy,
  output logic [FRAC_BITS-1:0]      fz
);

  localparam int SH = FRAC_BITS;

  logic [2:0]           v;
  logic [CELL_W-1:0]    cy1, cz1;
  hash_t                a0, a1;
  logic [FRAC_BITS-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
  logic [CELL_W-1:0]    cz2;
  hash_t                b [4];
  logic [CELL_W-1:0]    cxs, cys, czs;
  logic [COORD_W+7:0]   ex, ey, ez;

  assign ex  = {{8{coord_x[COORD_W-1]}}, coord_x};
  assign ey  = {{8{coord_y[COORD_W-1]}}, coord_y};
  assign ez  = {{8{coord_z[COORD_W-1]}}, coord_z};
  assign cxs = ex[SH +: CELL_W];
  assign cys = ey[SH +: CELL_W];
  assign czs = ez[SH +: CELL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0  <= perm(cxs);
      a1  <= perm(cxs + 8'd1);
      cy1 <= cys;
      cz1 <= czs;
      x1  <= coord_x[FRAC_BITS-1:0];
      y1  <= coord_y[FRAC_BITS-1:0];
      z1  <= coord_z[FRAC_BITS-1:0];
      for (int j = 0; j < 4; j++) begin
        b[j] <= perm((j[0] ? a1 : a0) + cy1 + {7'd0, j[1]});
      end
      cz2 <= cz1;
      x2  <= x1; y2 <= y1; z2 <= z1;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= perm(b[i[1:0]] + cz2 + {7'd0, i[2]});
      end
      x3  <= x2; y3 <= y2; z3 <= z2;
    end
  end

  assign out_valid = v[2];
  assign fx = x3;
  assign fy = y3;
  assign fz = z3;

endmodule

// ===== sv/gn3_back.sv =====
module gn3_back import gn3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int OUT_BITS  = OUT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  hash_t                hash [8],
  input  logic [FRAC_BITS-1:0] fx,
  input  logic [FRAC_BITS-1:0] fy,
  input  logic [FRAC_BITS-1:0] fz,
  input  logic                 adv,
  output logic                 out_valid,
  output logic [OUT_BITS-1:0]  result
);

  localparam int F  = FRAC_BITS;
  localparam int W  = F + 5;
  localparam int PW = 2 * F + 8;
  localparam int VW = W + 2;
  localparam logic signed [W-1:0] ONE = W'(1) <<< F;

  logic [6:0] v;

  logic [F-1:0]      t1 [3];
  logic [F-1:0]      q1 [3];
  logic [F-1:0]      c2 [3];
  logic signed [F+5:0] p2 [3];
  logic signed [W-1:0] s3 [3];
  logic signed [W-1:0] s4 [3];
  logic signed [W-1:0] s5 [3];

  logic signed [W-1:0] g1 [8], g2 [8], g3 [8];
  logic signed [W-1:0] l4 [4];
  logic signed [W-1:0] l5 [2];
  logic signed [W-1:0] n6;
  logic [OUT_BITS-1:0] r7;

  function automatic logic signed [W-1:0] grad(input logic [3:0] k,
      input logic signed [W-1:0] x, input logic signed [W-1:0] y,
      input logic signed [W-1:0] z);
    logic signed [W-1:0] uu, vv;
    uu = (k < 4'd8) ? x : y;
    vv = (k < 4'd4) ? y : ((k == GRAD_12 || k == GRAD_14) ? x : z);
    grad = (k[0] ? -uu : uu) + (k[1] ? -vv : vv);
  endfunction

  function automatic logic signed [W-1:0] lrp(input logic signed [W-1:0] a,
      input logic signed [W-1:0] bb, input logic signed [W-1:0] s);
    logic signed [PW-1:0] m;
    m = PW'(s) * PW'(bb - a);
    lrp = a + W'(m >>> F);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    logic [2*F-1:0] qq, cc;
    logic signed [PW-1:0] pp;
    logic signed [W-1:0] ox, oy, oz, vx;
    if (adv) begin
      t1[0] <= fx; t1[1] <= fy; t1[2] <= fz;
      for (int a = 0; a < 3; a++) begin
        qq = (a == 0 ? fx : (a == 1 ? fy : fz)) * (a == 0 ? fx : (a == 1 ? fy : fz));
        q1[a] <= qq[2*F-1:F];
        cc = q1[a] * t1[a];
        c2[a] <= cc[2*F-1:F];
        p2[a] <= $signed({2'd0, 4'd10, {F{1'b0}}})
                 + $signed((F+6)'(6) * (F+6)'(q1[a])) - $signed((F+6)'(15) * (F+6)'(t1[a]));
        pp = PW'($signed({1'b0, c2[a]})) * PW'(p2[a]);
        s3[a] <= W'(pp >>> F);
        s4[a] <= s3[a];
        s5[a] <= s4[a];
      end
      for (int i = 0; i < 8; i++) begin
        ox = $signed({5'd0, fx}) - (i[0] ? ONE : W'(0));
        oy = $signed({5'd0, fy}) - (i[1] ? ONE : W'(0));
        oz = $signed({5'd0, fz}) - (i[2] ? ONE : W'(0));
        g1[i] <= grad(hash[i][3:0], ox, oy, oz);
        g2[i] <= g1[i];
        g3[i] <= g2[i];
      end
      for (int j = 0; j < 4; j++) begin
        l4[j] <= lrp(g3[2*j], g3[2*j+1], s3[0]);
      end
      for (int j = 0; j < 2; j++) begin
        l5[j] <= lrp(l4[2*j], l4[2*j+1], s4[1]);
      end
      n6 <= lrp(l5[0], l5[1], s5[2]);
      vx = n6 + ONE;
      if (vx <= 0) begin
        r7 <= '0;
      end else if (OUT_BITS >= F + 1) begin
        r7 <= ((VW+OUT_BITS)'(vx) << (OUT_BITS - F - 1)) > (VW+OUT_BITS)'({OUT_BITS{1'b1}})
              ? '1 : OUT_BITS'((VW+OUT_BITS)'(vx) << (OUT_BITS - F - 1));
      end else begin
        r7 <= (W'(vx >>> (F + 1 - OUT_BITS)) > W'({OUT_BITS{1'b1}}))
              ? '1 : OUT_BITS'(vx >>> (F + 1 - OUT_BITS));
      end
    end
  end

  assign out_valid = v[6];
  assign result    = r7;

endmodule

// ===== sv/gn3_fifo.sv =====
module gn3_fifo import gn3_pkg::*; #(
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  logic [DW-1:0] wdata,
  input  logic          rd,
  output logic          nempty,
  output logic [DW-1:0] rdata,
  output logic [2:0]    count
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [DW-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + {2'd0, wr} - {2'd0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  assign nempty = count != 3'd0;
  assign rdata  = mem[rp];

  assert property (@(posedge clk) disable iff (rst) count <= 3'(QUEUE_DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) !(rd && count == 3'd0))
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (rst) wr && !rd |=> count != 3'd0)
    else $error("queue lost word");

endmodule

// ===== sv/gradient_noise_3d.sv =====
// A pushed point passes the hash front end, a 4-entry queue and the blend back end
// to the result ports. Throughput: one point per cycle while full is low; the queue
// between the front end and the back end lets each stall on its own.
// A word held on the result ports stalls the back end; the front end then fills
// the queue and raises full.
// Reset (rst, synchronous, active high) empties both pipelines and the queue.
module gradient_noise_3d import gn3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int OUT_BITS  = OUT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  output logic                      empty,
  input  logic                      pop,
  output logic [OUT_BITS-1:0]       noise_value
);

  localparam int MW = 8 * HASH_W + 3 * FRAC_BITS;

  logic                 fv, bv, acc, fadv, fwr, mrd, mnempty, badv;
  hash_t                fh [8];
  hash_t                bh [8];
  logic [FRAC_BITS-1:0] ffx, ffy, ffz, bfx, bfy, bfz;
  logic [MW-1:0]        mq_w, mq_r;
  logic [2:0]           mcount;
  logic [OUT_BITS-1:0]  res;

  assign full = mcount == 3'(QUEUE_DEPTH);
  assign fadv = !full;
  assign acc  = push && !full;
  assign fwr  = fv && fadv;
  assign badv = !bv || pop;
  assign mrd  = mnempty && badv;

  gn3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(acc), .coord_x(coord_x), .coord_y(coord_y),
    .coord_z(coord_z), .adv(fadv), .out_valid(fv), .hash(fh), .fx(ffx), .fy(ffy), .fz(ffz)
  );

  assign mq_w = {fh[0], fh[1], fh[2], fh[3], fh[4], fh[5], fh[6], fh[7], ffx, ffy, ffz};
  assign {bh[0], bh[1], bh[2], bh[3], bh[4], bh[5], bh[6], bh[7], bfx, bfy, bfz} = mq_r;

  gn3_fifo #(.DW(MW)) u_queue (
    .clk(clk), .rst(rst), .wr(fwr), .wdata(mq_w), .rd(mrd), .nempty(mnempty),
    .rdata(mq_r), .count(mcount)
  );

  gn3_back #(.FRAC_BITS(FRAC_BITS), .OUT_BITS(OUT_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(mnempty), .hash(bh), .fx(bfx), .fy(bfy), .fz(bfz),
    .adv(badv), .out_valid(bv), .result(res)
  );

  assign empty       = !bv;
  assign noise_value = res;

  assert property (@(posedge clk) disable iff (rst) full |-> !acc)
    else $error("accept while full");
  assert property (@(posedge clk) disable iff (rst) bv && !pop |=> bv && $stable(noise_value))
    else $error("word changed while waiting");
  assert property (@(posedge clk) disable iff (rst) !empty |-> !$isunknown(noise_value))
    else $error("unknown word");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import gn3_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int OB = OUT_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [OB-1:0] noise_value;

  logic [OB-1:0] pending_noise[$];
  int errors = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  bit burst = 1'b0;

  typedef struct {
    logic [COORD_W-1:0] x, y, z;
    bit known;
    logic [OB-1:0] value;
  } point_row_t;

  gradient_noise_3d i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .empty(empty), .pop(pop), .noise_value(noise_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint floor_div(longint v);
    if (v >= 0) return v >>> FB;
    return -(((-(v + 1)) >>> FB) + 1);
  endfunction

  function automatic longint smooth(longint t);
    longint q, c, p;
    q = (t * t) >>> FB;
    c = (q * t) >>> FB;
    p = 10 * ONE + 6 * q - 15 * t;
    return (c * p) >>> FB;
  endfunction

  function automatic longint mix(longint a, longint b, longint s);
    return a + floor_div(s * (b - a));
  endfunction

  function automatic longint grad_sum(logic [3:0] k, longint x, longint y, longint z);
    longint u, v;
    u = (k < 8) ? x : y;
    v = (k < 4) ? y : ((k == GRAD_12 || k == GRAD_14) ? x : z);
    return (k[0] ? -u : u) + (k[1] ? -v : v);
  endfunction

  function automatic logic [OB-1:0] noise_of(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                             logic [COORD_W-1:0] pz);
    longint sx, sy, sz, f[3], s[3], acc[8], n, r, ox, oy, oz;
    logic [7:0] c[3], a, b, h;
    sx = longint'(signed'(px));
    sy = longint'(signed'(py));
    sz = longint'(signed'(pz));
    c[0] = 8'(sx >>> FB); c[1] = 8'(sy >>> FB); c[2] = 8'(sz >>> FB);
    f[0] = sx & (ONE - 1); f[1] = sy & (ONE - 1); f[2] = sz & (ONE - 1);
    for (int j = 0; j < 3; j++) s[j] = smooth(f[j]);
    for (int i = 0; i < 8; i++) begin
      a = PERM_ROM[8'(c[0] + i[0])];
      b = PERM_ROM[8'(a + c[1] + i[1])];
      h = PERM_ROM[8'(b + c[2] + i[2])];
      ox = i[0] ? f[0] - ONE : f[0];
      oy = i[1] ? f[1] - ONE : f[1];
      oz = i[2] ? f[2] - ONE : f[2];
      acc[i] = grad_sum(h[3:0], ox, oy, oz);
    end
    n = mix(mix(mix(acc[0], acc[1], s[0]), mix(acc[2], acc[3], s[0]), s[1]),
            mix(mix(acc[4], acc[5], s[0]), mix(acc[6], acc[7], s[0]), s[1]), s[2]) + ONE;
    if (n <= 0) r = 0;
    else if (OB >= FB + 1) r = n << (OB - FB - 1);
    else r = n >> (FB + 1 - OB);
    if (r > (longint'(1) << OB) - 1) r = (longint'(1) << OB) - 1;
    return OB'(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic gap(int lo_len, int hi_len);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(lo_len, hi_len) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                            logic [COORD_W-1:0] pz, bit known, logic [OB-1:0] value);
    coord_x <= px;
    coord_y <= py;
    coord_z <= pz;
    push <= 1'b1;
    do @(posedge clk); while (full);
    if (known && noise_of(px, py, pz) != value)
      report_mismatch("table row vs predictor", noise_of(px, py, pz), value);
    pending_noise.push_back(noise_of(px, py, pz));
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'h800000 | 24'($urandom_range(0, 255));
      1: return 24'h7FFF00 | 24'($urandom_range(0, 255));
      2: return {8'($urandom), 16'h0000};
      3: return {8'($urandom), 16'hFFFF};
      default: return 24'($urandom);
    endcase
  endfunction

  point_row_t rows[] = '{
    '{24'h000000, 24'h000000, 24'h000000, 1'b1, 16'd32768},
    '{24'h010000, 24'h020000, 24'h030000, 1'b1, 16'd32768},
    '{24'h800000, 24'h800000, 24'h800000, 1'b1, 16'd32768},
    '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 16'd0},
    '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 16'd0},
    '{24'h008000, 24'h008000, 24'h008000, 1'b0, 16'd0},
    '{24'hFF8000, 24'h008000, 24'hFF8000, 1'b0, 16'd0},
    '{24'h00FFFF, 24'h000000, 24'h00FFFF, 1'b0, 16'd0},
    '{24'h000001, 24'hFFFFFF, 24'h000001, 1'b0, 16'd0},
    '{24'h7F8000, 24'h808000, 24'h004000, 1'b0, 16'd0},
    '{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0, 16'd0},
    '{24'h555555, 24'hAAAAAA, 24'h555555, 1'b0, 16'd0},
    '{24'hFF0000, 24'h00C000, 24'h014000, 1'b0, 16'd0}
  };

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].value);
      gap(5, 30);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) burst <= 1'b1;
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
      if (i < 100 || i > 200) gap(5, 40);
    end
    push <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    wait (burst);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (pop && !empty) begin
        if (pending_noise.size() == 0) begin
          report_mismatch("unexpected word", noise_value, -1);
        end else begin
          if (noise_value !== pending_noise[0])
            report_mismatch("noise_value", noise_value, pending_noise[0]);
          void'(pending_noise.pop_front());
        end
      end
      if (hold_off || rx_wait > 0) begin
        pop <= 1'b0;
        if (rx_wait > 0) rx_wait <= rx_wait - 1;
      end else if ($urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        rx_wait <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (pending_noise.size() != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gradient_noise_3d: mismatch");
      $finish;
    end else begin
      repeat (30) @(posedge clk);
      if (errors == 0 && pending_noise.size() == 0) begin
        $display("gradient_noise_3d: match");
      end else begin
        $display("gradient_noise_3d: mismatch");
      end
      $finish;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("gradient_noise_3d: mismatch");
    $finish;
  end

endmodule
